// File: hw/rtl/hsw_pkg.sv
// Shared constants, types and the sine lookup for the hum and swing synthesizer.
package hsw_pkg;

  // Sample clock of the audio stream.
  localparam int unsigned SAMPLE_RATE_HZ = 16000;

  // Field widths
  localparam int FREQ_W   = 13;
  localparam int GAIN_W   = 7;
  localparam int PHASE_W  = 32;
  localparam int POS_W    = 24;
  localparam int MS_W     = 16;
  localparam int LEVEL_W  = 8;
  localparam int NOISE_W  = 16;
  localparam int ACTION_W = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_HUM_FREQ_A       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_FREQ_B       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_FREQ     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_START_FREQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_END_FREQ   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWING_TONE_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWING_NOISE_GAIN = 3'd6;

  localparam logic [FREQ_W-1:0] RST_HUM_FREQ_A       = 13'd60;
  localparam logic [FREQ_W-1:0] RST_HUM_FREQ_B       = 13'd63;
  localparam logic [FREQ_W-1:0] RST_VIBRATO_FREQ     = 13'd4;
  localparam logic [FREQ_W-1:0] RST_SWEEP_START_FREQ = 13'd300;
  localparam logic [FREQ_W-1:0] RST_SWEEP_END_FREQ   = 13'd1500;
  localparam logic [GAIN_W-1:0] RST_SWING_TONE_GAIN  = 7'd60;
  localparam logic [GAIN_W-1:0] RST_SWING_NOISE_GAIN = 7'd80;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK    = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_TRIGGER = 1'b1;

  // Noise generator
  localparam logic [NOISE_W-1:0] NOISE_SEED = 16'hACE1;
  localparam logic [NOISE_W-1:0] NOISE_TAPS = 16'hB400;

  // Mix constants
  localparam logic [7:0] HUM_GAIN       = 8'd55;
  localparam logic [7:0] HUM_NOISE_GAIN = 8'd25;
  localparam logic [7:0] ENV_FULL       = 8'd255;
  localparam logic [MS_W-1:0] DEFAULT_MS = 16'd100;

  // Serial divider sizing
  localparam int DIV_NUM_W = 45;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_DEN_W-1:0] DEN_STEP = DIV_DEN_W'(SAMPLE_RATE_HZ);
  localparam logic [DIV_DEN_W-1:0] DEN_PCT  = 24'd100;
  localparam logic [DIV_DEN_W-1:0] DEN_ENV  = 24'd255;
  localparam logic [DIV_DEN_W-1:0] DEN_MS   = 24'd1000;
  localparam logic [MS_W-1:0]      RATE16   = MS_W'(SAMPLE_RATE_HZ);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;   // left aligned
    logic [DIV_DEN_W-1:0] denom;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [FREQ_W-1:0] hum_freq_a;
    logic [FREQ_W-1:0] hum_freq_b;
    logic [FREQ_W-1:0] vibrato_freq;
    logic [FREQ_W-1:0] sweep_start_freq;
    logic [FREQ_W-1:0] sweep_end_freq;
    logic [GAIN_W-1:0] swing_tone_gain;
    logic [GAIN_W-1:0] swing_noise_gain;
  } hsw_cfg_t;

  // First quadrant of round(128 + 127*sin), offsets from the midpoint
  localparam logic [7:0] QUARTER_SINE [0:64] = '{
    8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd16,  8'd19,  8'd22,
    8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
    8'd49,  8'd51,  8'd54,  8'd57,  8'd60,  8'd63,  8'd65,  8'd68,
    8'd71,  8'd73,  8'd76,  8'd78,  8'd81,  8'd83,  8'd85,  8'd88,
    8'd90,  8'd92,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd104,
    8'd106, 8'd107, 8'd109, 8'd111, 8'd112, 8'd113, 8'd115, 8'd116,
    8'd117, 8'd118, 8'd120, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124,
    8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127,
    8'd127
  };

  // Sine level from the top eight phase bits, mirrored over four quadrants
  function automatic logic [7:0] sine_at(input logic [PHASE_W-1:0] phase);
    logic [5:0] r;
    logic [1:0] quad;
    logic [6:0] ti;
    logic [7:0] d;
    r    = phase[29:24];
    quad = phase[31:30];
    ti   = quad[0] ? (7'd64 - {1'b0, r}) : {1'b0, r};
    d    = QUARTER_SINE[ti];
    return quad[1] ? (8'd128 - d) : (8'd128 + d);
  endfunction

endpackage

// File: hw/rtl/hsw_if.sv
// Request and result channel interfaces of the synthesizer.
interface hsw_req_if;
  logic                           valid;
  logic                           ready;
  logic [hsw_pkg::ACTION_W-1:0]   action;
  logic [hsw_pkg::MS_W-1:0]       duration_ms;

  modport source (output valid, action, duration_ms, input ready);
  modport sink (input valid, action, duration_ms, output ready);
endinterface

interface hsw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [hsw_pkg::LEVEL_W-1:0]    pwm_level;
  logic                           swing_playing;

  modport source (output valid, pwm_level, swing_playing, input ready);
  modport sink (input valid, pwm_level, swing_playing, output ready);
endinterface

// File: hw/rtl/hum_and_swing_sound_synth.sv
// Hum and swing sound synthesizer: one 8-bit PWM level per tick request. A swing tick
// skips the sweep division when the sweep holds at its start frequency. The work runs
// on one shared divider that makes one quotient bit per cycle; it handles every
// increment, sweep frequency, envelope and percent gain. One request is worked on at
// a time; a finished level waits in the output register while the next request is
// taken. Configuration writes are registered and are meant for idle time.
module hum_and_swing_sound_synth (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [hsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  hsw_req_if.sink                         req,
  hsw_rsp_if.source                       rsp
);

  // Sequencer states
  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_TRIG      = 5'd1;
  localparam logic [4:0] ST_SW_FREQ   = 5'd2;
  localparam logic [4:0] ST_SW_STEP   = 5'd3;
  localparam logic [4:0] ST_SW_ENV    = 5'd4;
  localparam logic [4:0] ST_SW_TONE   = 5'd5;
  localparam logic [4:0] ST_SW_NOISE  = 5'd6;
  localparam logic [4:0] ST_SW_SCALE  = 5'd7;
  localparam logic [4:0] ST_HM_VIB    = 5'd8;
  localparam logic [4:0] ST_HM_A      = 5'd9;
  localparam logic [4:0] ST_HM_A_MUL  = 5'd10;
  localparam logic [4:0] ST_HM_A_ADD  = 5'd11;
  localparam logic [4:0] ST_HM_B      = 5'd12;
  localparam logic [4:0] ST_HM_B_MUL  = 5'd13;
  localparam logic [4:0] ST_HM_B_ADD  = 5'd14;
  localparam logic [4:0] ST_HM_MIX_A  = 5'd15;
  localparam logic [4:0] ST_HM_MIX_B  = 5'd16;
  localparam logic [4:0] ST_HM_MIX_N  = 5'd17;
  localparam logic [4:0] ST_OUT       = 5'd18;

  localparam logic [hsw_pkg::DIV_CNT_W-1:0] NB_STEP  = 6'd45;
  localparam logic [hsw_pkg::DIV_CNT_W-1:0] NB_SWEEP = 6'd37;
  localparam logic [hsw_pkg::DIV_CNT_W-1:0] NB_WORD  = 6'd32;
  localparam logic [hsw_pkg::DIV_CNT_W-1:0] NB_SMALL = 6'd17;

  hsw_pkg::hsw_cfg_t cfg;
  hsw_pkg::div_req_t div_req;
  hsw_pkg::div_rsp_t div_rsp;

  // Sequencer and model state
  logic [4:0]                       state;
  logic                             issued;
  logic [hsw_pkg::PHASE_W-1:0]      phase_a;
  logic [hsw_pkg::PHASE_W-1:0]      phase_b;
  logic [hsw_pkg::PHASE_W-1:0]      vphase;
  logic [hsw_pkg::NOISE_W-1:0]      noise;
  logic                             swing_on;
  logic [hsw_pkg::POS_W-1:0]        pos;
  logic [hsw_pkg::POS_W-1:0]        len;

  // Scratch registers of one request
  logic [hsw_pkg::MS_W-1:0]         dur;
  logic [hsw_pkg::FREQ_W-1:0]       freq_sw;
  logic [hsw_pkg::PHASE_W-1:0]      inc;
  logic [7:0]                       env;
  logic signed [2:0]                off;
  logic signed [35:0]               prod;
  logic signed [11:0]               acc;
  logic [hsw_pkg::LEVEL_W-1:0]      lvl;
  logic                             lvl_swing;

  // Output register
  logic                             out_valid;
  logic [hsw_pkg::LEVEL_W-1:0]      out_level;
  logic                             out_swing;

  // Combinational helpers
  logic                             op_state;
  logic                             op_done;
  logic [hsw_pkg::POS_W-1:0]        len_eff;
  logic [hsw_pkg::MS_W-1:0]         ms_eff;
  logic [31:0]                      ms_prod;
  logic [hsw_pkg::FREQ_W-1:0]       sweep_span;
  logic                             sweep_up;
  logic [36:0]                      sweep_prod;
  logic [31:0]                      env_prod;
  logic signed [11:0]               sval;
  logic signed [11:0]               sval_neg;
  logic [8:0]                       sabs;
  logic [7:0]                       small_k;
  logic [16:0]                      small_mag;
  logic signed [11:0]               q_small;
  logic signed [11:0]               small_res;
  logic [hsw_pkg::NOISE_W-1:0]      noise_next;
  logic [hsw_pkg::POS_W-1:0]        tq;
  logic [hsw_pkg::POS_W-1:0]        len_new;
  logic [hsw_pkg::POS_W-1:0]        pos_inc;
  logic [hsw_pkg::PHASE_W-1:0]      vphase_new;
  logic [7:0]                       vib_sine;
  logic signed [35:0]               prod_adj;
  logic signed [35:0]               delta36;
  logic [hsw_pkg::PHASE_W-1:0]      delta;
  logic [7:0]                       tone;
  logic [7:0]                       hum_a;
  logic [7:0]                       hum_b;

  // Level relative to the midpoint, as a signed byte
  function automatic logic signed [11:0] centered(input logic [7:0] x);
    logic signed [7:0] c;
    c = $signed({~x[7], x[6:0]});
    return 12'(c);
  endfunction

  // Back to 0..255 around the midpoint
  function automatic logic [7:0] clamp_level(input logic signed [11:0] v);
    logic signed [11:0] s;
    s = v + 12'sd128;
    if (s < 12'sd0) begin
      return 8'd0;
    end else if (s > 12'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  hsw_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hsw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Operand preparation
  assign len_eff    = (len == '0) ? hsw_pkg::POS_W'(1) : len;
  assign ms_eff     = (dur == '0) ? hsw_pkg::DEFAULT_MS : dur;
  assign ms_prod    = 32'(ms_eff) * 32'(hsw_pkg::RATE16);
  assign sweep_up   = (cfg.sweep_end_freq > cfg.sweep_start_freq);
  assign sweep_span = cfg.sweep_end_freq - cfg.sweep_start_freq;
  assign sweep_prod = 37'(sweep_span) * 37'(pos);
  assign env_prod   = 32'(len_eff - pos) * 32'(hsw_pkg::ENV_FULL);
  assign noise_next = (noise >> 1) ^ (noise[0] ? hsw_pkg::NOISE_TAPS : '0);
  assign tone       = hsw_pkg::sine_at(phase_a);
  assign hum_a      = hsw_pkg::sine_at(phase_a);
  assign hum_b      = hsw_pkg::sine_at(phase_b);

  // Signed operand and gain of the percent and envelope steps
  always_comb begin
    sval    = '0;
    small_k = '0;
    case (state)
      ST_SW_TONE: begin
        sval    = centered(tone);
        small_k = 8'(cfg.swing_tone_gain);
      end
      ST_SW_NOISE: begin
        sval    = centered(noise[7:0]);
        small_k = 8'(cfg.swing_noise_gain);
      end
      ST_SW_SCALE: begin
        sval    = acc;
        small_k = env;
      end
      ST_HM_MIX_A: begin
        sval    = centered(hum_a);
        small_k = hsw_pkg::HUM_GAIN;
      end
      ST_HM_MIX_B: begin
        sval    = centered(hum_b);
        small_k = hsw_pkg::HUM_GAIN;
      end
      ST_HM_MIX_N: begin
        sval    = centered(noise[7:0]);
        small_k = hsw_pkg::HUM_NOISE_GAIN;
      end
      default: ;
    endcase
  end

  // Divide magnitudes, then restore the sign: truncation toward zero
  assign sval_neg  = -sval;
  assign sabs      = sval[11] ? sval_neg[8:0] : sval[8:0];
  assign small_mag = 17'(sabs) * 17'(small_k);
  assign q_small   = $signed({2'b00, div_rsp.quot[9:0]});
  assign small_res = sval[11] ? -q_small : q_small;

  // Divider request per state
  assign op_state = state inside {ST_TRIG, ST_SW_FREQ, ST_SW_STEP, ST_SW_ENV, ST_SW_TONE,
                                  ST_SW_NOISE, ST_SW_SCALE, ST_HM_VIB, ST_HM_A, ST_HM_B,
                                  ST_HM_MIX_A, ST_HM_MIX_B, ST_HM_MIX_N};
  assign op_done  = issued && !div_rsp.busy;

  always_comb begin
    div_req.start = op_state && !issued && !((state == ST_SW_FREQ) && !sweep_up);
    div_req.numer = {small_mag, 28'b0};
    div_req.denom = hsw_pkg::DEN_PCT;
    div_req.nbits = NB_SMALL;
    case (state)
      ST_TRIG: begin
        div_req.numer = {ms_prod, 13'b0};
        div_req.denom = hsw_pkg::DEN_MS;
        div_req.nbits = NB_WORD;
      end
      ST_SW_FREQ: begin
        div_req.numer = {sweep_prod, 8'b0};
        div_req.denom = len_eff;
        div_req.nbits = NB_SWEEP;
      end
      ST_SW_STEP: begin
        div_req.numer = {freq_sw, 32'b0};
        div_req.denom = hsw_pkg::DEN_STEP;
        div_req.nbits = NB_STEP;
      end
      ST_SW_ENV: begin
        div_req.numer = {env_prod, 13'b0};
        div_req.denom = len_eff;
        div_req.nbits = NB_WORD;
      end
      ST_HM_VIB: begin
        div_req.numer = {cfg.vibrato_freq, 32'b0};
        div_req.denom = hsw_pkg::DEN_STEP;
        div_req.nbits = NB_STEP;
      end
      ST_HM_A: begin
        div_req.numer = {cfg.hum_freq_a, 32'b0};
        div_req.denom = hsw_pkg::DEN_STEP;
        div_req.nbits = NB_STEP;
      end
      ST_HM_B: begin
        div_req.numer = {cfg.hum_freq_b, 32'b0};
        div_req.denom = hsw_pkg::DEN_STEP;
        div_req.nbits = NB_STEP;
      end
      ST_SW_SCALE: div_req.denom = hsw_pkg::DEN_ENV;
      default: ;
    endcase
  end

  // Trigger length, at least one sample
  assign tq      = div_rsp.quot[hsw_pkg::POS_W-1:0];
  assign len_new = (tq == '0) ? hsw_pkg::POS_W'(1) : tq;
  assign pos_inc = pos + hsw_pkg::POS_W'(1);

  // Vibrato offset (v >> 5) - 4 is the top three sine bits with the MSB flipped
  assign vphase_new = vphase + div_rsp.quot[hsw_pkg::PHASE_W-1:0];
  assign vib_sine   = hsw_pkg::sine_at(vphase_new);

  // Increment wobble: product / 128 truncated toward zero
  assign prod_adj = prod[35] ? (prod + 36'sd127) : prod;
  assign delta36  = prod_adj >>> 7;
  assign delta    = delta36[hsw_pkg::PHASE_W-1:0];

  // Sequencer with the synthesizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      phase_a   <= '0;
      phase_b   <= '0;
      vphase    <= '0;
      noise     <= hsw_pkg::NOISE_SEED;
      swing_on  <= 1'b0;
      pos       <= '0;
      len       <= '0;
    end else begin
      if (op_state) begin
        if (div_req.start) begin
          issued <= 1'b1;
        end else if (op_done) begin
          issued <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.action == hsw_pkg::ACT_TRIGGER) begin
              dur   <= req.duration_ms;
              state <= ST_TRIG;
            end else begin
              noise <= noise_next;
              state <= swing_on ? ST_SW_FREQ : ST_HM_VIB;
            end
          end
        end
        ST_TRIG: begin
          if (op_done) begin
            len      <= len_new;
            pos      <= '0;
            swing_on <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_SW_FREQ: begin
          if (!sweep_up) begin
            freq_sw <= cfg.sweep_start_freq;
            state   <= ST_SW_STEP;
          end else if (op_done) begin
            freq_sw <= cfg.sweep_start_freq + div_rsp.quot[hsw_pkg::FREQ_W-1:0];
            state   <= ST_SW_STEP;
          end
        end
        ST_SW_STEP: begin
          if (op_done) begin
            phase_a <= phase_a + div_rsp.quot[hsw_pkg::PHASE_W-1:0];
            state   <= ST_SW_ENV;
          end
        end
        ST_SW_ENV: begin
          if (op_done) begin
            env   <= div_rsp.quot[7:0];
            state <= ST_SW_TONE;
          end
        end
        ST_SW_TONE: begin
          if (op_done) begin
            acc   <= small_res;
            state <= ST_SW_NOISE;
          end
        end
        ST_SW_NOISE: begin
          if (op_done) begin
            acc   <= acc + small_res;
            state <= ST_SW_SCALE;
          end
        end
        ST_SW_SCALE: begin
          if (op_done) begin
            lvl       <= clamp_level(small_res);
            lvl_swing <= 1'b1;
            // Advance the swing; it ends after its last sample
            if ((pos_inc >= len_eff) || (pos_inc == '0)) begin
              swing_on <= 1'b0;
              pos      <= '0;
              len      <= '0;
            end else begin
              pos <= pos_inc;
            end
            state <= ST_OUT;
          end
        end
        ST_HM_VIB: begin
          if (op_done) begin
            vphase <= vphase_new;
            off    <= $signed({~vib_sine[7], vib_sine[6:5]});
            state  <= ST_HM_A;
          end
        end
        ST_HM_A: begin
          if (op_done) begin
            inc   <= div_rsp.quot[hsw_pkg::PHASE_W-1:0];
            state <= ST_HM_A_MUL;
          end
        end
        ST_HM_A_MUL: begin
          prod  <= $signed({{4{inc[31]}}, inc}) * $signed({{33{off[2]}}, off});
          state <= ST_HM_A_ADD;
        end
        ST_HM_A_ADD: begin
          phase_a <= phase_a + inc + delta;
          state   <= ST_HM_B;
        end
        ST_HM_B: begin
          if (op_done) begin
            inc   <= div_rsp.quot[hsw_pkg::PHASE_W-1:0];
            state <= ST_HM_B_MUL;
          end
        end
        ST_HM_B_MUL: begin
          prod  <= $signed({{4{inc[31]}}, inc}) * $signed({{33{off[2]}}, off});
          state <= ST_HM_B_ADD;
        end
        ST_HM_B_ADD: begin
          phase_b <= phase_b + inc + delta;
          state   <= ST_HM_MIX_A;
        end
        ST_HM_MIX_A: begin
          if (op_done) begin
            acc   <= small_res;
            state <= ST_HM_MIX_B;
          end
        end
        ST_HM_MIX_B: begin
          if (op_done) begin
            acc   <= acc + small_res;
            state <= ST_HM_MIX_N;
          end
        end
        ST_HM_MIX_N: begin
          if (op_done) begin
            lvl       <= clamp_level(acc + small_res);
            lvl_swing <= 1'b0;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: holds a level until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!out_valid || rsp.ready)) begin
      out_level <= lvl;
      out_swing <= lvl_swing;
    end
  end

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.pwm_level     = out_level;
  assign rsp.swing_playing = out_swing;

endmodule

// File: hw/rtl/hsw_regs.sv
// Configuration register file of the synthesizer.
module hsw_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [hsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsw_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hsw_pkg::hsw_cfg_t                cfg
);

  // Register writes, indexed by position in the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hum_freq_a       <= hsw_pkg::RST_HUM_FREQ_A;
      cfg.hum_freq_b       <= hsw_pkg::RST_HUM_FREQ_B;
      cfg.vibrato_freq     <= hsw_pkg::RST_VIBRATO_FREQ;
      cfg.sweep_start_freq <= hsw_pkg::RST_SWEEP_START_FREQ;
      cfg.sweep_end_freq   <= hsw_pkg::RST_SWEEP_END_FREQ;
      cfg.swing_tone_gain  <= hsw_pkg::RST_SWING_TONE_GAIN;
      cfg.swing_noise_gain <= hsw_pkg::RST_SWING_NOISE_GAIN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hsw_pkg::REG_HUM_FREQ_A:       cfg.hum_freq_a       <= cfg_data;
        hsw_pkg::REG_HUM_FREQ_B:       cfg.hum_freq_b       <= cfg_data;
        hsw_pkg::REG_VIBRATO_FREQ:     cfg.vibrato_freq     <= cfg_data;
        hsw_pkg::REG_SWEEP_START_FREQ: cfg.sweep_start_freq <= cfg_data;
        hsw_pkg::REG_SWEEP_END_FREQ:   cfg.sweep_end_freq   <= cfg_data;
        hsw_pkg::REG_SWING_TONE_GAIN:  cfg.swing_tone_gain  <= cfg_data[hsw_pkg::GAIN_W-1:0];
        hsw_pkg::REG_SWING_NOISE_GAIN: cfg.swing_noise_gain <= cfg_data[hsw_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/hsw_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
module hsw_div (
  input  logic                 clk,
  input  logic                 rst,
  input  hsw_pkg::div_req_t    req,
  output hsw_pkg::div_rsp_t    rsp
);

  logic                             busy;
  logic [hsw_pkg::DIV_CNT_W-1:0]    cnt;
  logic [hsw_pkg::DIV_NUM_W-1:0]    num_sr;
  logic [hsw_pkg::DIV_NUM_W-1:0]    quot;
  logic [hsw_pkg::DIV_DEN_W-1:0]    den;
  logic [hsw_pkg::DIV_DEN_W-1:0]    rem;
  logic [hsw_pkg::DIV_DEN_W:0]      trial;
  logic [hsw_pkg::DIV_DEN_W:0]      diff;
  logic                             fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem, num_sr[hsw_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  // Bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.nbits;
    end else if (busy) begin
      cnt <= cnt - hsw_pkg::DIV_CNT_W'(1);
      if (cnt == hsw_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift registers for dividend, remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sr <= req.numer;
      den    <= req.denom;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sr <= {num_sr[hsw_pkg::DIV_NUM_W-2:0], 1'b0};
      rem    <= fits ? diff[hsw_pkg::DIV_DEN_W-1:0] : trial[hsw_pkg::DIV_DEN_W-1:0];
      quot   <= {quot[hsw_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.quot = quot;

endmodule

// File: hw/rtl/hsw_checker.sv
// Port-level checks of the synthesizer, bound to its top level.
module hsw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [hsw_pkg::LEVEL_W-1:0]   pwm_level,
  input logic                          swing_playing
);

  // After reset the block takes requests and shows no result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (req_ready && !rsp_valid))
    else $error("not idle after reset");

  // One request at a time: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // A result never appears in the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("result without work");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(pwm_level) && $stable(swing_playing)))
    else $error("stalled result changed");

endmodule

bind hum_and_swing_sound_synth hsw_checker u_hsw_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .pwm_level     (rsp.pwm_level),
  .swing_playing (rsp.swing_playing)
);
